// ----- rtl/gic_pkg.sv -----
// ----------------------------------------------------------------------------
// gic_pkg
// Shared constants and types for the GPIO interrupt controller: register
// offsets, default pin count and the per-access result bundle.
// ----------------------------------------------------------------------------
package gic_pkg;

  localparam int unsigned DefPinCount = 32;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned OffWidth    = 12;

  // register map, byte offsets
  localparam logic [OffWidth-1:0] OffDir  = 12'h000;
  localparam logic [OffWidth-1:0] OffOut  = 12'h004;
  localparam logic [OffWidth-1:0] OffIn   = 12'h008;
  localparam logic [OffWidth-1:0] OffIe   = 12'h00C;
  localparam logic [OffWidth-1:0] OffIs   = 12'h010;
  localparam logic [OffWidth-1:0] OffTrig = 12'h014;
  localparam logic [OffWidth-1:0] OffPol  = 12'h018;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_level;
    logic                 access_error;
  } gic_res_t;

endpackage

// ----- rtl/gic_regs.sv -----
// ----------------------------------------------------------------------------
// gic_regs
// Register file and interrupt evaluation: applies one bus request per cycle
// and presents its result combinationally from the current state.
// ----------------------------------------------------------------------------
module gic_regs import gic_pkg::*; #(
  parameter int unsigned PinCount = DefPinCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_i,
  input  logic                 command_i,
  input  logic [OffWidth-1:0]  offset_i,
  input  logic [DataWidth-1:0] write_data_i,
  output gic_res_t             res_o
);

  logic [PinCount-1:0] dir_q, dir_d;
  logic [PinCount-1:0] out_q, out_d;
  logic [PinCount-1:0] prev_q, prev_d;
  logic [PinCount-1:0] ie_q, ie_d;
  logic [PinCount-1:0] is_q, is_d;
  logic [PinCount-1:0] trig_q, trig_d;
  logic [PinCount-1:0] pol_q, pol_d;
  logic                clr_q, clr_d;
  logic                irq_q, irq_d;

  logic [PinCount-1:0] data;
  logic [PinCount-1:0] watched;
  logic [PinCount-1:0] match;
  logic [PinCount-1:0] fire;
  logic [PinCount-1:0] is_cleared;
  logic [PinCount-1:0] rd_bits;
  logic                do_eval;
  logic                err;

  assign data = write_data_i[PinCount-1:0];

  always_comb begin
    dir_d      = dir_q;
    out_d      = out_q;
    prev_d     = prev_q;
    ie_d       = ie_q;
    is_d       = is_q;
    trig_d     = trig_q;
    pol_d      = pol_q;
    clr_d      = clr_q;
    irq_d      = irq_q;
    rd_bits    = '0;
    do_eval    = 1'b0;
    err        = 1'b0;
    is_cleared = is_q & ~data;

    if (command_i == CmdRead) begin
      unique case (offset_i)
        OffDir:        rd_bits = dir_q;
        OffOut, OffIn: rd_bits = out_q;
        OffIe:         rd_bits = ie_q;
        OffIs:         rd_bits = is_q;
        OffTrig:       rd_bits = trig_q;
        OffPol:        rd_bits = pol_q;
        default:       err = 1'b1;
      endcase
    end else begin
      unique case (offset_i)
        OffDir: begin
          dir_d   = data;
          do_eval = 1'b1;
        end
        OffOut: begin
          out_d   = data;
          do_eval = 1'b1;
        end
        OffIe: begin
          ie_d    = data;
          do_eval = 1'b1;
        end
        OffTrig: begin
          trig_d  = data;
          do_eval = 1'b1;
        end
        OffPol: begin
          pol_d   = data;
          do_eval = 1'b1;
        end
        OffIs: begin
          is_d = is_cleared;
          if (is_cleared == '0) begin
            irq_d = 1'b0;
            clr_d = 1'b1;
          end
        end
        default: err = 1'b1;
      endcase
    end

    // evaluation sees the freshly written register values
    watched = ie_d & dir_d;
    match   = ~(out_d ^ pol_d);
    fire    = (trig_d & match) | (~trig_d & (prev_q ^ out_d) & match);

    if (do_eval) begin
      prev_d = out_d;
      if (clr_q) begin
        // first evaluation after a full status clear is swallowed
        clr_d = 1'b0;
        irq_d = 1'b0;
      end else begin
        is_d  = (is_q & ~watched) | (watched & fire);
        irq_d = |is_d;
      end
    end

    res_o                         = '0;
    res_o.read_data[PinCount-1:0] = rd_bits;
    res_o.irq_level               = irq_d;
    res_o.access_error            = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= '0;
      out_q  <= '0;
      prev_q <= '0;
      ie_q   <= '0;
      is_q   <= '0;
      trig_q <= '0;
      pol_q  <= '0;
      clr_q  <= 1'b0;
      irq_q  <= 1'b0;
    end else if (req_i) begin
      dir_q  <= dir_d;
      out_q  <= out_d;
      prev_q <= prev_d;
      ie_q   <= ie_d;
      is_q   <= is_d;
      trig_q <= trig_d;
      pol_q  <= pol_d;
      clr_q  <= clr_d;
      irq_q  <= irq_d;
    end
  end

endmodule

// ----- rtl/gpio_interrupt_controller_unit.sv -----
// ----------------------------------------------------------------------------
// gpio_interrupt_controller_unit
// GPIO register block with edge and level pin interrupts, one bus request
// per cycle while not stalled, result via an output register and skid stage.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, command_i,        | request in
//           | offset_i, write_data_i                    |
//   out     | out_valid_o, out_stall_i, read_data_o,    | result out
//           | irq_level_o, access_error_o               |
//
// One request per cycle while in_stall_o is low; update and evaluation are
// combinational, the result registered into the output or skid register.
// Reset clears all pin registers, the interrupt state and both valid flags.
// A stalled output keeps accepting one more request into the skid stage;
// in_stall_o rises only while that stage is full.
// ----------------------------------------------------------------------------
module gpio_interrupt_controller_unit import gic_pkg::*; #(
  parameter int unsigned PinCount = DefPinCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [OffWidth-1:0]  offset_i,
  input  logic [DataWidth-1:0] write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DataWidth-1:0] read_data_o,
  output logic                 irq_level_o,
  output logic                 access_error_o
);

  gic_res_t res;
  gic_res_t out_q;
  gic_res_t skid_q;
  logic     out_valid_q;
  logic     skid_valid_q;
  logic     accept;
  logic     out_held;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_held   = out_valid_q & out_stall_i;

  gic_regs #(
    .PinCount(PinCount)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (accept),
    .command_i   (command_i),
    .offset_i    (offset_i),
    .write_data_i(write_data_i),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_held) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (out_held) begin
      if (accept) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_q.read_data;
  assign irq_level_o    = out_q.irq_level;
  assign access_error_o = out_q.access_error;

endmodule
